[design/sobel_edge_frame_pipeline_assert.svh]
// Assertion macros used by the sobel edge frame pipeline sequencer
`ifndef SOBEL_EDGE_FRAME_PIPELINE_ASSERT_SVH
`define SOBEL_EDGE_FRAME_PIPELINE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SEFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sefp check failed");

// next-cycle implication
`define SEFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sefp check failed");

`endif

[design/sefp_pkg.sv]
// Types, constants and kernel tables for the sobel edge frame pipeline
package sefp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_CFG_W  = 9;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned THR2_W     = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_e;

  localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH    = 9'd256;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT   = 9'd256;
  localparam logic [THR_W-1:0]     RST_EDGE_THRESHOLD = 11'd80;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] frame_width;
    logic [DIM_CFG_W-1:0] frame_height;
    logic [THR_W-1:0]     edge_threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] edge_byte;
    logic       last_pixel;
    logic       not_ready;
  } edge_res_t;

  typedef struct packed {
    logic       is_read;
    logic [7:0] gray;
  } cmd_t;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = 2;

  // 3x3 window sequencing: taps 0..8 issue reads, 9 takes the last data, 10 writes
  localparam int unsigned TAP_W = 4;
  localparam logic [TAP_W-1:0] TAP_DONE = 4'd10;

  localparam int unsigned ACC_W  = 12;
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned WT_W   = 14;

  localparam logic [WT_W-1:0] WT_CENTER = 14'd13381;
  localparam logic [WT_W-1:0] WT_EDGE   = 14'd8116;
  localparam logic [WT_W-1:0] WT_CORNER = 14'd4923;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLUR,
    ST_SOBEL,
    ST_LAP
  } seq_state_e;

  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [WT_W-1:0] blur_wt(input logic [TAP_W-1:0] k);
    logic [WT_W-1:0] w;
    case (k)
      4'd4:                   w = WT_CENTER;
      4'd1, 4'd3, 4'd5, 4'd7: w = WT_EDGE;
      4'd0, 4'd2, 4'd6, 4'd8: w = WT_CORNER;
      default:                w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [3:0] gx_coef(input logic [TAP_W-1:0] k);
    logic signed [3:0] c;
    case (k)
      4'd0, 4'd6: c = 4'sd1;
      4'd2, 4'd8: c = -4'sd1;
      4'd3:       c = 4'sd2;
      4'd5:       c = -4'sd2;
      default:    c = 4'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [3:0] gy_coef(input logic [TAP_W-1:0] k);
    logic signed [3:0] c;
    case (k)
      4'd0, 4'd2: c = 4'sd1;
      4'd1:       c = 4'sd2;
      4'd6, 4'd8: c = -4'sd1;
      4'd7:       c = -4'sd2;
      default:    c = 4'sd0;
    endcase
    return c;
  endfunction

  // 255*x mod 256 is -x mod 256, so accumulate the negated Laplacian directly
  function automatic logic signed [3:0] lap_coef(input logic [TAP_W-1:0] k);
    logic signed [3:0] c;
    case (k)
      4'd4:                   c = -4'sd4;
      4'd1, 4'd3, 4'd5, 4'd7: c = 4'sd1;
      default:                c = 4'sd0;
    endcase
    return c;
  endfunction

  // floor(sum/3) for sum <= 765: 683/2048 overshoots by less than the slack
  function automatic logic [7:0] gray_of(input logic [9:0] sum);
    logic [20:0] p;
    p = 21'(sum) * 21'd683;
    return p[18:11];
  endfunction

endpackage

[design/sefp_ram.sv]
// Generic simple dual-port RAM with registered read
module sefp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/sefp_front.sv]
// Request intake: gray conversion and command queue toward the sequencer
module sefp_front import sefp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_req_t req_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t               cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_AW:0]   cnt_q, cnt_d;
  logic               accept;
  logic               take;
  logic [9:0]         rgb_sum;
  cmd_t               cmd_new;

  assign full_o      = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_ptr_q];
  assign accept      = push_i & ~full_o;
  assign take        = cmd_pop_i & cmd_valid_o;

  assign rgb_sum         = 10'(req_i.red) + 10'(req_i.green) + 10'(req_i.blue);
  assign cmd_new.is_read = req_i.mode;
  assign cmd_new.gray    = gray_of(rgb_sum);

  always_comb begin
    wr_ptr_d = accept ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = take ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (CMDQ_AW+1)'(accept) - (CMDQ_AW+1)'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmdq_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[design/sefp_back.sv]
// Frame sequencer: pixel store, blur/Sobel passes, Laplacian reads
`include "sobel_edge_frame_pipeline_assert.svh"

module sefp_back import sefp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output edge_res_t res_o,
  input  logic      res_pop_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);

  seq_state_e          state_q, state_d;
  logic [TAP_W-1:0]    tap_q, tap_d;
  logic [NW-1:0]       lc_q, lc_d;
  logic                ready_q, ready_d;
  logic [WW-1:0]       act_w_q, act_w_d;
  logic [HW-1:0]       act_h_q, act_h_d;
  logic [NW-1:0]       act_n_q, act_n_d;
  logic [THR2_W-1:0]   thr2_q, thr2_d;
  logic [RW-1:0]       row_q;
  logic [CW-1:0]       col_q;
  logic [AW-1:0]       rbase_q;
  logic [ACC_W-1:0]    sum_q, sum_d;
  logic signed [GRAD_W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic                res_valid_q;
  edge_res_t           res_q;

  logic [WW-1:0]       cfg_w;
  logic [HW-1:0]       cfg_h;
  logic [NW-1:0]       n_cfg;
  logic [NW-1:0]       lc_eff, idx_full, idx_next;

  logic                col_last, row_last, pix_last;
  logic [CW-1:0]       col_prev, col_next, col_sel;
  logic [AW-1:0]       base_prev, base_next, base_sel;
  logic [AW-1:0]       rd_addr, center_addr;
  logic [TAP_W-1:0]    dk;

  logic [7:0]          gray_rd, blur_rd, rd_pix;
  logic                edge_rd;
  logic [21:0]         bprod;
  logic signed [GRAD_W-1:0] pv, cx, cy;
  logic signed [3:0]   kx;
  logic [GRAD_W-2:0]   ax, ay;
  logic [THR2_W-1:0]   grad_sq;
  logic [7:0]          blur_val;
  logic                edge_bit;

  logic                g_we, b_we, e_we;
  logic                pos_clr, adv;
  logic                produce, out_free;
  edge_res_t           res_new;

  // dimension clamp: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      cfg_w = WW'(1);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      cfg_h = HW'(1);
    end else if (32'(cfg_i.frame_height) > MAX_HEIGHT) begin
      cfg_h = HW'(MAX_HEIGHT);
    end else begin
      cfg_h = HW'(cfg_i.frame_height);
    end
  end

  assign n_cfg    = NW'(cfg_w) * NW'(cfg_h);
  assign lc_eff   = ready_q ? '0 : lc_q;
  assign idx_full = (lc_eff < n_cfg) ? lc_eff : n_cfg - NW'(1);
  assign idx_next = idx_full + NW'(1);

  // window geometry with wrap-around on all borders
  assign col_last  = (WW'(col_q) + WW'(1) == act_w_q);
  assign row_last  = (HW'(row_q) + HW'(1) == act_h_q);
  assign pix_last  = col_last & row_last;
  assign col_prev  = (col_q == '0) ? CW'(act_w_q - WW'(1)) : col_q - CW'(1);
  assign col_next  = col_last ? '0 : col_q + CW'(1);
  assign base_prev = (row_q == '0) ? AW'(act_n_q - NW'(act_w_q)) : rbase_q - AW'(act_w_q);
  assign base_next = row_last ? '0 : rbase_q + AW'(act_w_q);

  always_comb begin
    case (tap_row(tap_q))
      2'd0:    base_sel = base_prev;
      2'd1:    base_sel = rbase_q;
      default: base_sel = base_next;
    endcase
    case (tap_col(tap_q))
      2'd0:    col_sel = col_prev;
      2'd1:    col_sel = col_q;
      default: col_sel = col_next;
    endcase
  end

  assign rd_addr     = base_sel + AW'(col_sel);
  assign center_addr = rbase_q + AW'(col_q);
  assign dk          = tap_q - TAP_W'(1);

  always_comb begin
    case (state_q)
      ST_BLUR:  rd_pix = gray_rd;
      ST_SOBEL: rd_pix = blur_rd;
      default:  rd_pix = {7'd0, edge_rd};
    endcase
  end

  assign bprod = 22'(rd_pix) * 22'(blur_wt(dk));
  assign pv    = $signed({3'b000, rd_pix});
  assign kx    = (state_q == ST_LAP) ? lap_coef(dk) : gx_coef(dk);
  assign cx    = GRAD_W'(kx);
  assign cy    = GRAD_W'(gy_coef(dk));

  always_comb begin
    if (tap_q == '0) begin
      sum_d = '0;
      gx_d  = '0;
      gy_d  = '0;
    end else if (tap_q != TAP_DONE) begin
      sum_d = sum_q + ACC_W'(bprod[21:16]);
      gx_d  = gx_q + pv * cx;
      gy_d  = gy_q + pv * cy;
    end else begin
      sum_d = sum_q;
      gx_d  = gx_q;
      gy_d  = gy_q;
    end
  end

  assign blur_val = (sum_q > ACC_W'(255)) ? 8'd255 : sum_q[7:0];
  assign ax       = gx_q[GRAD_W-1] ? (GRAD_W-1)'(-gx_q) : (GRAD_W-1)'(gx_q);
  assign ay       = gy_q[GRAD_W-1] ? (GRAD_W-1)'(-gy_q) : (GRAD_W-1)'(gy_q);
  assign grad_sq  = THR2_W'(ax) * THR2_W'(ax) + THR2_W'(ay) * THR2_W'(ay);
  assign edge_bit = (grad_sq >= thr2_q);

  assign out_free = ~res_valid_q | res_pop_i;

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    lc_d      = lc_q;
    ready_d   = ready_q;
    act_w_d   = act_w_q;
    act_h_d   = act_h_q;
    act_n_d   = act_n_q;
    thr2_d    = thr2_q;
    cmd_pop_o = 1'b0;
    g_we      = 1'b0;
    b_we      = 1'b0;
    e_we      = 1'b0;
    pos_clr   = 1'b0;
    adv       = 1'b0;
    produce   = 1'b0;
    res_new   = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_read) begin
            cmd_pop_o = 1'b1;
            g_we      = 1'b1;
            ready_d   = 1'b0;
            lc_d      = idx_next;
            if (idx_next >= n_cfg) begin
              act_w_d = cfg_w;
              act_h_d = cfg_h;
              act_n_d = n_cfg;
              thr2_d  = THR2_W'(cfg_i.edge_threshold) * THR2_W'(cfg_i.edge_threshold);
              pos_clr = 1'b1;
              tap_d   = '0;
              state_d = ST_BLUR;
            end
          end else if (!ready_q) begin
            if (out_free) begin
              cmd_pop_o         = 1'b1;
              produce           = 1'b1;
              res_new.not_ready = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            tap_d     = '0;
            state_d   = ST_LAP;
          end
        end
      end
      ST_BLUR, ST_SOBEL: begin
        if (tap_q == TAP_DONE) begin
          b_we  = (state_q == ST_BLUR);
          e_we  = (state_q == ST_SOBEL);
          tap_d = '0;
          if (pix_last) begin
            pos_clr = 1'b1;
            if (state_q == ST_BLUR) begin
              state_d = ST_SOBEL;
            end else begin
              state_d = ST_IDLE;
              ready_d = 1'b1;
            end
          end else begin
            adv = 1'b1;
          end
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      ST_LAP: begin
        if (tap_q == TAP_DONE) begin
          if (out_free) begin
            produce            = 1'b1;
            res_new.edge_byte  = gx_q[7:0];
            res_new.last_pixel = pix_last;
            tap_d              = '0;
            state_d            = ST_IDLE;
            if (pix_last) begin
              ready_d = 1'b0;
              lc_d    = '0;
              pos_clr = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        tap_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      lc_q        <= '0;
      ready_q     <= 1'b0;
      act_w_q     <= WW'(1);
      act_h_q     <= HW'(1);
      act_n_q     <= NW'(1);
      thr2_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rbase_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      lc_q        <= lc_d;
      ready_q     <= ready_d;
      act_w_q     <= act_w_d;
      act_h_q     <= act_h_d;
      act_n_q     <= act_n_d;
      thr2_q      <= thr2_d;
      res_valid_q <= produce | (res_valid_q & ~res_pop_i);
      if (pos_clr) begin
        row_q   <= '0;
        col_q   <= '0;
        rbase_q <= '0;
      end else if (adv) begin
        if (col_last) begin
          col_q   <= '0;
          row_q   <= row_q + RW'(1);
          rbase_q <= rbase_q + AW'(act_w_q);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    if (produce) begin
      res_q <= res_new;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  sefp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_gray_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (idx_full[AW-1:0]),
    .wdata_i (cmd_i.gray),
    .raddr_i (rd_addr),
    .rdata_o (gray_rd)
  );

  sefp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_blur_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (center_addr),
    .wdata_i (blur_val),
    .raddr_i (rd_addr),
    .rdata_o (blur_rd)
  );

  sefp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (center_addr),
    .wdata_i (edge_bit),
    .raddr_i (rd_addr),
    .rdata_o (edge_rd)
  );

  `SEFP_ASSERT_IMP(a_one_mem_write, 1'b1, $onehot0({g_we, b_we, e_we}))
  `SEFP_ASSERT_IMP(a_idle_tap_clear, state_q == ST_IDLE, tap_q == '0)
  `SEFP_ASSERT_IMP(a_lap_only_ready, state_q == ST_LAP, ready_q)
  `SEFP_ASSERT_NXT(a_res_held, res_valid_q && !res_pop_i, res_valid_q && $stable(res_q))

endmodule

[design/sobel_edge_frame_pipeline.sv]
// Sobel edge frame pipeline top level: config registers, intake and sequencer
//
// Pixels are pushed in raster order (mode 0) and stored as gray; the idle
// sequencer takes loads from the queue at one per cycle. When the frame's
// last pixel lands, the sequencer runs a Gaussian blur pass and then a Sobel
// threshold pass, each stepping every pixel through a single read port of
// the pixel memories (9 window reads, one drain, one write); queued requests
// wait during the passes. Each read request (mode 0 being a load, 1 a read)
// is taken from the queue by the idle sequencer, which then forms the
// Laplacian of the edge map from 9 window reads and holds it until the
// result slot is free; a read before the frame is complete returns not_ready.
// A four-entry request queue lets pushes continue while the sequencer is
// busy or a result waits to be popped.
module sobel_edge_frame_pipeline import sefp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  pix_req_t              req_i,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output edge_res_t             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_regs_t cfg_q;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= RST_FRAME_WIDTH;
      cfg_q.frame_height   <= RST_FRAME_HEIGHT;
      cfg_q.edge_threshold <= RST_EDGE_THRESHOLD;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i[DIM_CFG_W-1:0];
        REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  sefp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sefp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res_o),
    .res_pop_i   (pop & res_valid)
  );

  assign empty = ~res_valid;

endmodule

[test/sefp_checker.sv]
// Predictor and result checker for the sobel edge frame pipeline
`timescale 1ns / 100ps

module sefp_checker import sefp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  pix_req_t              req_i,
  input  logic                  pop_i,
  input  logic                  empty_i,
  input  edge_res_t             res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int MAX_PIX = 256 * 256;

  logic [7:0] gray_mem [MAX_PIX];
  logic [7:0] blur_mem [MAX_PIX];
  logic       edge_mem [MAX_PIX];

  logic [DIM_CFG_W-1:0] width_reg, height_reg;
  logic [THR_W-1:0]     thresh_reg;
  int                   loaded, readout, frame_w, frame_h;
  bit                   frame_done;
  edge_res_t            edge_results_q [$];

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // 0 = gray, 1 = blur, 2 = edge map; neighbor at offset (dr, dc) with wrap
  function automatic int tap(int sel, int r, int c, int dr, int dc);
    int rr, cc;
    rr = (r + frame_h + dr) % frame_h;
    cc = (c + frame_w + dc) % frame_w;
    case (sel)
      0:       return gray_mem[rr * frame_w + cc];
      1:       return blur_mem[rr * frame_w + cc];
      default: return edge_mem[rr * frame_w + cc];
    endcase
  endfunction

  task automatic filter_frame();
    int sum, wt, gx, gy, t2;
    t2 = thresh_reg * thresh_reg;
    for (int r = 0; r < frame_h; r++)
      for (int c = 0; c < frame_w; c++) begin
        sum = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) wt = 13381;
            else if (dr == 0 || dc == 0) wt = 8116;
            else wt = 4923;
            sum += (tap(0, r, c, dr, dc) * wt) >> 16;
          end
        blur_mem[r * frame_w + c] = (sum > 255) ? 8'd255 : sum[7:0];
      end
    for (int r = 0; r < frame_h; r++)
      for (int c = 0; c < frame_w; c++) begin
        gx = tap(1, r, c, -1, -1) - tap(1, r, c, -1, 1)
           + 2 * (tap(1, r, c, 0, -1) - tap(1, r, c, 0, 1))
           + tap(1, r, c, 1, -1) - tap(1, r, c, 1, 1);
        gy = tap(1, r, c, -1, -1) + 2 * tap(1, r, c, -1, 0) + tap(1, r, c, -1, 1)
           - tap(1, r, c, 1, -1) - 2 * tap(1, r, c, 1, 0) - tap(1, r, c, 1, 1);
        edge_mem[r * frame_w + c] = (gx * gx + gy * gy >= t2);
      end
  endtask

  task automatic predict(pix_req_t p);
    int w, h, n, idx, v;
    edge_res_t e;
    if (!p.mode) begin
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      n = w * h;
      if (frame_done) begin
        frame_done = 0;
        loaded = 0;
        readout = 0;
      end
      idx = (loaded < n) ? loaded : n - 1;
      gray_mem[idx] = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
      loaded = idx + 1;
      if (loaded >= n) begin
        frame_w = w;
        frame_h = h;
        filter_frame();
        frame_done = 1;
        readout = 0;
      end
    end else if (!frame_done) begin
      e = '{edge_byte: 8'd0, last_pixel: 1'b0, not_ready: 1'b1};
      edge_results_q.push_back(e);
    end else begin
      n = frame_w * frame_h;
      idx = (readout < n) ? readout : n - 1;
      v = 4 * 255 * tap(2, idx / frame_w, idx % frame_w, 0, 0)
        - 255 * (tap(2, idx / frame_w, idx % frame_w, -1, 0)
               + tap(2, idx / frame_w, idx % frame_w, 0, -1)
               + tap(2, idx / frame_w, idx % frame_w, 0, 1)
               + tap(2, idx / frame_w, idx % frame_w, 1, 0));
      e.edge_byte  = v[7:0];
      e.last_pixel = (idx + 1 >= n);
      e.not_ready  = 1'b0;
      edge_results_q.push_back(e);
      if (e.last_pixel) begin
        frame_done = 0;
        loaded = 0;
        readout = 0;
      end else begin
        readout = idx + 1;
      end
    end
  endtask

  task automatic report(string field, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_res_t want;
    if (!rst_ni) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thresh_reg = RST_EDGE_THRESHOLD;
      loaded = 0;
      readout = 0;
      frame_done = 0;
      frame_w = 1;
      frame_h = 1;
      fail_count_o = 0;
      edge_results_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (edge_results_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = edge_results_q.pop_front();
          if (res_i.edge_byte !== want.edge_byte)
            report("edge_byte", res_i.edge_byte, want.edge_byte);
          if (res_i.last_pixel !== want.last_pixel)
            report("last_pixel", res_i.last_pixel, want.last_pixel);
          if (res_i.not_ready !== want.not_ready)
            report("not_ready", res_i.not_ready, want.not_ready);
        end
      end
      if (push_i && !full_i) predict(req_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH:    width_reg  = cfg_data_i[DIM_CFG_W-1:0];
          REG_FRAME_HEIGHT:   height_reg = cfg_data_i[DIM_CFG_W-1:0];
          REG_EDGE_THRESHOLD: thresh_reg = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = edge_results_q.size();
  end

endmodule

[test/testbench.sv]
// Stimulus, idling control and verdict for the sobel edge frame pipeline
`timescale 1ns / 100ps

module testbench;
  import sefp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  // worst case: both filter passes over a 256-pixel frame plus queued requests
  localparam int DRAIN_CYCLES = 22 * 256 + 100;

  logic                  clk = 0, rst_n = 0;
  logic                  push = 0, pop = 0, full, empty;
  pix_req_t              req = '0;
  edge_res_t             res;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fails, pending, items;
  int                    idle_cycles = 0;
  int                    send_idle_pct, recv_stall_pct;

  sobel_edge_frame_pipeline uut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .req_i(req), .full(full),
    .empty(empty), .pop(pop), .res_o(res),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  sefp_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .req_i(req),
    .pop_i(pop), .empty_i(empty), .res_i(res),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(pix_req_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= p;
    do @(posedge clk); while (full);
    items++;
  endtask

  task automatic load_pixel(int r, int g, int b);
    pix_req_t p;
    p.mode  = 1'b0;
    p.red   = r[7:0];
    p.green = g[7:0];
    p.blue  = b[7:0];
    send(p);
  endtask

  task automatic read_pixel();
    pix_req_t p;
    p.mode  = 1'b1;
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    send(p);
  endtask

  function automatic int color();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // block is quiet: no result owed and no filter pass still running
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int thr);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, thr);
  endtask

  initial begin
    int w, h, n, reads, pick;
    items = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read before any frame, width 0 acting as 1, threshold 0
    read_pixel();
    set_frame(0, 2, 0);
    write_reg(IDX_SPARE, 2047);
    load_pixel(255, 255, 255);
    load_pixel(0, 0, 0);
    read_pixel();
    read_pixel();
    read_pixel();
    // load while ready abandons the frame
    set_frame(2, 2, 2047);
    repeat (4) load_pixel(color(), color(), color());
    read_pixel();
    settle();
    write_reg(REG_EDGE_THRESHOLD, 1443);
    load_pixel(255, 0, 255);
    // frame shrinks during load
    set_frame(4, 2, 20);
    repeat (5) load_pixel(color(), color(), color());
    settle();
    write_reg(REG_FRAME_WIDTH, 2);
    load_pixel(0, 255, 0);
    repeat (4) read_pixel();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      while (items < 140 * (phase + 1)) begin
        pick = $urandom_range(19);
        if (pick == 0) begin w = 511; h = 1; end
        else if (pick == 1) begin w = 1; h = 256; end
        else if (pick == 2) begin w = 0; h = $urandom_range(1, 6); end
        else begin w = $urandom_range(1, 9); h = $urandom_range(1, 9); end
        case ($urandom_range(5))
          0:       set_frame(w, h, 0);
          1:       set_frame(w, h, 1443);
          2:       set_frame(w, h, 2047);
          default: set_frame(w, h, $urandom_range(300));
        endcase
        n = ((w < 1) ? 1 : (w > 256) ? 256 : w) * h;
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(29) == 0) read_pixel();
          load_pixel(color(), color(), color());
        end
        // now and then stop reading early so the next frame abandons this one
        reads = ($urandom_range(7) == 0) ? $urandom_range(n) : n;
        for (int i = 0; i < reads; i++) read_pixel();
        if ($urandom_range(9) == 0) read_pixel();
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sobel_edge_frame_pipeline.f]
+incdir+design
design/sefp_pkg.sv
design/sefp_ram.sv
design/sefp_front.sv
design/sefp_back.sv
design/sobel_edge_frame_pipeline.sv
test/sefp_checker.sv
test/testbench.sv
